FILE: hdl/cioc_pkg.sv
// Package for the custom I/O credit controller: sequencer states, mode codes,
// pricing tables and fixed-point reciprocals.
// Depends on nothing; imported by the top level.
`default_nettype none

package cioc_pkg;

	localparam int REG_COUNT  = 16;
	localparam int OFF_W      = $clog2(REG_COUNT);
	localparam int CHIP_COUNT = 2;
	localparam int RAM_DEPTH  = REG_COUNT * CHIP_COUNT;
	localparam int RAM_AW     = $clog2(RAM_DEPTH);

	localparam logic [OFF_W-1:0] OFF_MODE      = OFF_W'(8);
	localparam logic [OFF_W-1:0] OFF_TEST_ZERO = OFF_W'(9);

	localparam logic [7:0] MODE_PORTS_A = 8'd1;
	localparam logic [7:0] MODE_PORTS_B = 8'd3;
	localparam logic [7:0] MODE_CREDIT  = 8'd4;
	localparam logic [7:0] MODE_TEST    = 8'd8;
	localparam logic [7:0] MODE_ALT     = 8'd9;

	localparam logic [7:0] NIBBLE_ALL = 8'h0f;
	localparam logic [7:0] HIGH_MASK  = 8'h0c;
	localparam logic [7:0] CREDIT_MAX = 8'hff;

	localparam logic       CMD_WRITE = 1'b0;
	localparam logic       CMD_READ  = 1'b1;

	// floor(x / 3) = (x * RECIP3) >> RECIP3_SH for x < 2048
	localparam logic [9:0]  RECIP3     = 10'd683;
	localparam int          RECIP3_SH  = 11;
	// floor(x / 10) = (x * RECIP10) >> RECIP10_SH for x < 2048
	localparam logic [11:0] RECIP10    = 12'd3277;
	localparam int          RECIP10_SH = 15;
	localparam logic [3:0]  DECIMAL    = 4'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCALE,
		ST_DIGIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic scale;
		logic digit;
	} ctrl_t;

	function automatic logic [2:0] price_mul(input logic [2:0] sel);
		case (sel)
			3'd0:    price_mul = 3'd1;
			3'd1:    price_mul = 3'd2;
			3'd2:    price_mul = 3'd3;
			3'd3:    price_mul = 3'd6;
			3'd4:    price_mul = 3'd7;
			3'd5:    price_mul = 3'd1;
			3'd6:    price_mul = 3'd3;
			default: price_mul = 3'd1;
		endcase
	endfunction

	function automatic logic [1:0] price_div(input logic [2:0] sel);
		case (sel)
			3'd5:    price_div = 2'd2;
			3'd6:    price_div = 2'd2;
			3'd7:    price_div = 2'd3;
			default: price_div = 2'd1;
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: hdl/cioc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module cioc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/custom_io_credit_controller_unit.sv
// Top level of the custom I/O credit controller: two chip register files in one
// RAM, credit counter, mode decode and scaled credit readout.
// Depends on cioc_pkg and cioc_ram.
//
// Channel | Handshake           | Payload
// --------+---------------------+------------------------------------------------
// in      | in_valid / in_ready | command chip_select reg_offset write_data ports
// out     | out_valid/out_ready | read_data credit_count
//
// Each access runs through accept and RAM read, credit update, pricing scale
// (reciprocal multiply for a divisor of 3), then tens/units split and result load.
// One access is in flight at a time; the sequencer takes the next only from idle.
// Reset clears the register-file valid bits, mode shadows, credits and held flags.
// A stalled output holds the sequencer in its last step; credits are already final.
`default_nettype none

module custom_io_credit_controller_unit
	import cioc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             command,
	input  wire logic             chip_select,
	input  wire logic [OFF_W-1:0] reg_offset,
	input  wire logic [7:0]       write_data,
	input  wire logic [7:0]       port_zero,
	input  wire logic [7:0]       port_one,
	input  wire logic [7:0]       port_two,
	input  wire logic [7:0]       port_three,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [7:0]       read_data,
	output logic      [7:0]       credit_count
);

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic [RAM_DEPTH-1:0] valid_q;
	logic [7:0]           mode0_q, mode1_q;
	logic [7:0]           credit_q;
	logic                 coin_a_q, coin_b_q, start_a_q, start_b_q;
	logic                 out_valid_q;

	logic [RAM_AW-1:0]    in_addr;
	logic                 in_fire, wr_fire, rd_fire, load;
	logic [7:0]           ram_rd;

	logic                 cmd_s1, chip_s1, valid_s1;
	logic [OFF_W-1:0]     off_s1;
	logic [7:0]           p0_s1, p1_s1, p2_s1, p3_s1;
	logic [7:0]           stored_s2, credit_s2;
	logic [10:0]          scaled_s3;

	logic [7:0]           mode_sel;
	logic [7:0]           credit_d;
	logic                 coin_a_d, coin_b_d, start_a_d, start_b_d;

	logic [10:0]          prod;
	logic [21:0]          prod3;
	logic [10:0]          scaled_d;
	logic [22:0]          tens_full;
	logic [7:0]           tens;
	logic [10:0]          tens_x10;
	logic [3:0]           units;
	logic [7:0]           rd_d;

	assign in_ready = ctrl.capture;
	assign in_fire  = in_valid && in_ready;
	assign wr_fire  = in_fire && (command == CMD_WRITE);
	assign rd_fire  = in_fire && (command == CMD_READ);
	assign in_addr  = {chip_select, reg_offset};
	assign load     = ctrl.digit && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	cioc_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_regs (
		.clk    (clk),
		.wr_en  (wr_fire),
		.wr_addr(in_addr),
		.wr_data(write_data),
		.rd_en  (rd_fire),
		.rd_addr(in_addr),
		.rd_data(ram_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_READ;
			ST_READ:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_DIGIT;
			ST_DIGIT: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:  ctrl.capture = 1'b1;
			ST_READ:  ctrl.update  = 1'b1;
			ST_SCALE: ctrl.scale   = 1'b1;
			ST_DIGIT: ctrl.digit   = 1'b1;
			default:  ctrl = '0;
		endcase
	end

	assign mode_sel = chip_s1 ? mode1_q : mode0_q;

	always_comb begin
		logic [1:0] d;
		logic [2:0] cost_b;
		logic       upd;
		d        = price_div(p1_s1[2:0]);
		cost_b   = {d, 1'b0};
		upd      = (cmd_s1 == CMD_READ) && !chip_s1;
		credit_d = credit_q;
		coin_a_d = coin_a_q;
		coin_b_d = coin_b_q;
		start_a_d = start_a_q;
		start_b_d = start_b_q;
		if (upd) begin
			if (p3_s1[0]) begin
				if (!coin_a_d) begin
					if (credit_d != CREDIT_MAX) credit_d = credit_d + 8'd1;
					coin_a_d = 1'b1;
				end
			end else begin
				coin_a_d = 1'b0;
			end
			if (p3_s1[1]) begin
				if (!coin_b_d) begin
					if (credit_d != CREDIT_MAX) credit_d = credit_d + 8'd1;
					coin_b_d = 1'b1;
				end
			end else begin
				coin_b_d = 1'b0;
			end
			if (p3_s1[4]) begin
				if (!start_a_d && (credit_d >= {6'd0, d})) begin
					credit_d  = credit_d - {6'd0, d};
					start_a_d = 1'b1;
				end
			end else begin
				start_a_d = 1'b0;
			end
			if (p3_s1[5]) begin
				if (!start_b_d && (credit_d >= {5'd0, cost_b})) begin
					credit_d  = credit_d - {5'd0, cost_b};
					start_b_d = 1'b1;
				end
			end else begin
				start_b_d = 1'b0;
			end
		end
		if ((cmd_s1 == CMD_READ) && (mode_sel == MODE_TEST)) begin
			credit_d = 8'd0;
		end
	end

	always_comb begin
		prod  = {3'd0, credit_s2} * {8'd0, price_mul(p1_s1[2:0])};
		prod3 = {11'd0, prod} * {12'd0, RECIP3};
		case (price_div(p1_s1[2:0]))
			2'd2:    scaled_d = prod >> 1;
			2'd3:    scaled_d = prod3[RECIP3_SH +: 11];
			default: scaled_d = prod;
		endcase
	end

	assign tens_full = {12'd0, scaled_s3} * {11'd0, RECIP10};
	assign tens      = tens_full[RECIP10_SH +: 8];
	assign tens_x10  = {3'd0, tens} * {7'd0, DECIMAL};
	assign units     = 4'(scaled_s3 - tens_x10);

	always_comb begin
		rd_d = stored_s2;
		if (cmd_s1 == CMD_WRITE) begin
			rd_d = 8'd0;
		end else if (!chip_s1) begin
			if ((mode_sel == MODE_PORTS_A) || (mode_sel == MODE_PORTS_B)) begin
				case (off_s1)
					4'd0:    rd_d = {4'd0, p3_s1[3:0]};
					4'd1:    rd_d = {4'd0, p2_s1[3:0]};
					4'd2:    rd_d = 8'd0;
					4'd3:    rd_d = {4'd0, p3_s1[5:4], p3_s1[5:4]} | {4'd0, p2_s1[7:4]};
					4'd4, 4'd5, 4'd6, 4'd7: rd_d = NIBBLE_ALL;
					default: rd_d = stored_s2;
				endcase
			end else if (mode_sel == MODE_CREDIT) begin
				case (off_s1)
					4'd0:    rd_d = tens;
					4'd1:    rd_d = {4'd0, units};
					4'd4:    rd_d = {4'd0, p2_s1[3:0]};
					4'd5:    rd_d = {4'd0, p2_s1[7:4]};
					4'd6, 4'd7: rd_d = NIBBLE_ALL;
					default: rd_d = stored_s2;
				endcase
			end else if ((mode_sel == MODE_TEST) && (off_s1 >= OFF_TEST_ZERO)) begin
				rd_d = 8'd0;
			end
		end else begin
			if (mode_sel == MODE_PORTS_B) begin
				case (off_s1)
					4'd0, 4'd1, 4'd2, 4'd3: rd_d = 8'd0;
					4'd4:    rd_d = {4'd0, p0_s1[3:0]};
					4'd5:    rd_d = {4'd0, p1_s1[7:4]};
					4'd6:    rd_d = {4'd0, p1_s1[3:0]};
					4'd7:    rd_d = {4'd0, p3_s1[7:4]} & HIGH_MASK;
					default: rd_d = stored_s2;
				endcase
			end else if (mode_sel == MODE_ALT) begin
				case (off_s1)
					4'd0:    rd_d = {4'd0, p1_s1[3:0]};
					4'd1:    rd_d = {4'd0, p1_s1[7:4]};
					4'd3:    rd_d = {4'd0, p0_s1[3:0]};
					4'd4:    rd_d = {4'd0, p0_s1[7:4]};
					4'd2, 4'd5, 4'd7: rd_d = 8'd0;
					4'd6:    rd_d = {4'd0, p3_s1[7:4]} & HIGH_MASK;
					default: rd_d = stored_s2;
				endcase
			end else if ((mode_sel == MODE_TEST) && (off_s1 >= OFF_TEST_ZERO)) begin
				rd_d = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			mode0_q     <= 8'd0;
			mode1_q     <= 8'd0;
			credit_q    <= 8'd0;
			coin_a_q    <= 1'b0;
			coin_b_q    <= 1'b0;
			start_a_q   <= 1'b0;
			start_b_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_fire) begin
				valid_q[in_addr] <= 1'b1;
				if (reg_offset == OFF_MODE) begin
					if (chip_select) mode1_q <= write_data;
					else             mode0_q <= write_data;
				end
			end
			if (ctrl.update) begin
				credit_q  <= credit_d;
				coin_a_q  <= coin_a_d;
				coin_b_q  <= coin_b_d;
				start_a_q <= start_a_d;
				start_b_q <= start_b_d;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1   <= command;
			chip_s1  <= chip_select;
			off_s1   <= reg_offset;
			valid_s1 <= valid_q[in_addr];
			p0_s1    <= port_zero;
			p1_s1    <= port_one;
			p2_s1    <= port_two;
			p3_s1    <= port_three;
		end
		if (ctrl.update) begin
			stored_s2 <= valid_s1 ? ram_rd : 8'd0;
			credit_s2 <= credit_d;
		end
		if (ctrl.scale) begin
			scaled_s3 <= scaled_d;
		end
		if (load) begin
			read_data    <= rd_d;
			credit_count <= credit_q;
		end
	end

endmodule

`default_nettype wire
